/* hw/rtl/pvbr_pkg.sv */
// Shared types, command codes and a helper function for the page valid bitmap block.
package pvbr_pkg;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_INVAL = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] start_req;
    logic [7:0] length;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [6:0] run_start;
    logic [7:0] run_length;
    logic       page_empty;
    logic       last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
    logic fin;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic len_zero;
    logic is_scan;
    logic byte_adv;
    logic at_last;
  } dp_stat_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } find_t;

  // Lowest set bit of a byte.
  function automatic find_t first_one(input logic [7:0] v);
    find_t r;
    r.found = 1'b0;
    r.idx   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pvbr_ctrl.sv */
// Controller state machine that sequences decode, byte walk, flush and final result.
module pvbr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  pvbr_pkg::dp_stat_t   stat_i,
  output pvbr_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_FLUSH  = 5'b01000,
    ST_LAST   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.err || stat_i.len_zero) begin
          state_d = ST_LAST;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (stat_i.byte_adv && stat_i.at_last) begin
          state_d = stat_i.is_scan ? ST_FLUSH : ST_LAST;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_LAST;
      end
      ST_LAST: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* hw/rtl/pvbr_dp.sv */
// Datapath: bitmap registers, byte walker, run finder, pending run and result register.
module pvbr_dp #(
  parameter int PAGE_BYTES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvbr_pkg::req_t       req_i,
  input  pvbr_pkg::ctrl_cmd_t  cmd_i,
  output pvbr_pkg::dp_stat_t   stat_o,
  output pvbr_pkg::rsp_t       rsp_o,
  output logic                 rsp_strobe_o
);

  localparam int MapBytes = (PAGE_BYTES + 7) / 8;
  localparam int IdxW     = (MapBytes > 1) ? $clog2(MapBytes) : 1;

  logic [MapBytes-1:0][7:0] map_q, map_d;

  logic [1:0] cmd_q;
  logic [6:0] start_q;
  logic [7:0] end_q;
  logic       err_q, lenz_q;
  logic [3:0] last_byte_q;
  logic [3:0] byte_q, byte_d;
  logic [2:0] pos_q, pos_d;
  logic       inrun_q, inrun_d;
  logic [6:0] run_s_q, run_s_d;
  logic [7:0] run_l_q, run_l_d;
  logic       pend_v_q, pend_v_d;
  logic [6:0] pend_s_q, pend_s_d;
  logic [7:0] pend_l_q, pend_l_d;
  pvbr_pkg::rsp_t rsp_q, rsp_d;
  logic       strobe_q, strobe_d;

  logic [8:0] end9;
  logic [7:0] end_m1;
  logic       req_err;
  logic       is_scan;
  logic       page_empty;
  logic [7:0] cur_byte, rmask, m, ge_pos, ge_one;
  logic [7:0] pbit;
  pvbr_pkg::find_t one_r, zero_a, zero_b;

  logic       scan_adv;
  logic       run_done;
  logic [6:0] done_s;
  logic [7:0] done_l;

  assign end9    = {2'b00, req_i.start_req} + {1'b0, req_i.length};
  assign end_m1  = end9[7:0] - 8'd1;
  assign req_err = (end9 > 9'(PAGE_BYTES)) || (req_i.cmd == pvbr_pkg::CMD_RSVD);
  assign is_scan = (cmd_q == pvbr_pkg::CMD_SCAN);
  assign page_empty = ~|map_q;

  assign cur_byte = map_q[byte_q[IdxW-1:0]];

  // Bits of the current byte that lie inside the requested range.
  always_comb begin
    pbit  = '0;
    rmask = '0;
    for (int i = 0; i < 8; i++) begin
      pbit     = {1'b0, byte_q, 3'(i)};
      rmask[i] = (pbit >= {1'b0, start_q}) && (pbit < end_q);
    end
  end

  assign m      = cur_byte & rmask;
  assign ge_pos = 8'hFF << pos_q;
  assign one_r  = pvbr_pkg::first_one(m & ge_pos);
  assign zero_a = pvbr_pkg::first_one(~m & ge_pos);
  assign ge_one = 8'hFF << one_r.idx;
  assign zero_b = pvbr_pkg::first_one(~m & ge_one);

  // One step of the run finder over the current byte. A run that closes inside
  // the byte leaves the walker on that byte so later runs in it are found next.
  always_comb begin
    scan_adv = 1'b0;
    run_done = 1'b0;
    done_s   = run_s_q;
    done_l   = run_l_q;
    inrun_d  = inrun_q;
    run_s_d  = run_s_q;
    run_l_d  = run_l_q;
    pos_d    = pos_q;
    if (inrun_q) begin
      if (zero_a.found) begin
        run_done = 1'b1;
        done_l   = run_l_q + 8'(zero_a.idx - pos_q);
        inrun_d  = 1'b0;
        pos_d    = zero_a.idx;
      end else begin
        run_l_d  = run_l_q + (8'd8 - {5'b0, pos_q});
        scan_adv = 1'b1;
      end
    end else if (!one_r.found) begin
      scan_adv = 1'b1;
    end else if (zero_b.found) begin
      run_done = 1'b1;
      done_s   = {byte_q, one_r.idx};
      done_l   = 8'(zero_b.idx - one_r.idx);
      pos_d    = zero_b.idx;
    end else begin
      inrun_d  = 1'b1;
      run_s_d  = {byte_q, one_r.idx};
      run_l_d  = 8'd8 - {5'b0, one_r.idx};
      scan_adv = 1'b1;
    end
  end

  always_comb begin
    stat_o.err      = err_q;
    stat_o.len_zero = lenz_q;
    stat_o.is_scan  = is_scan;
    stat_o.byte_adv = is_scan ? scan_adv : 1'b1;
    stat_o.at_last  = (byte_q == last_byte_q);
  end

  // Bitmap update and walker pointer.
  always_comb begin
    map_d  = map_q;
    byte_d = byte_q;
    if (cmd_i.step && !is_scan) begin
      if (cmd_q == pvbr_pkg::CMD_MARK) begin
        map_d[byte_q[IdxW-1:0]] = cur_byte | rmask;
      end else begin
        map_d[byte_q[IdxW-1:0]] = cur_byte & ~rmask;
      end
    end
    if (cmd_i.step && stat_o.byte_adv) begin
      byte_d = byte_q + 4'd1;
    end
  end

  // A found run is held back one step so the final one can carry the last flag.
  always_comb begin
    pend_v_d = pend_v_q;
    pend_s_d = pend_s_q;
    pend_l_d = pend_l_q;
    strobe_d = 1'b0;
    rsp_d    = rsp_q;
    if ((cmd_i.step && is_scan && run_done) || (cmd_i.flush && inrun_q)) begin
      if (pend_v_q) begin
        strobe_d         = 1'b1;
        rsp_d.status     = 1'b0;
        rsp_d.run_start  = pend_s_q;
        rsp_d.run_length = pend_l_q;
        rsp_d.page_empty = page_empty;
        rsp_d.last       = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_s_d = cmd_i.flush ? run_s_q : done_s;
      pend_l_d = cmd_i.flush ? run_l_q : done_l;
    end
    if (cmd_i.fin) begin
      strobe_d         = 1'b1;
      rsp_d.status     = err_q;
      rsp_d.page_empty = page_empty;
      rsp_d.last       = 1'b1;
      if (!err_q && is_scan && pend_v_q) begin
        rsp_d.run_start  = pend_s_q;
        rsp_d.run_length = pend_l_q;
      end else begin
        rsp_d.run_start  = '0;
        rsp_d.run_length = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= '0;
      inrun_q  <= 1'b0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      map_q    <= map_d;
      strobe_q <= strobe_d;
      if (cmd_i.load) begin
        inrun_q  <= 1'b0;
        pend_v_q <= 1'b0;
      end else begin
        if (cmd_i.step && is_scan) begin
          inrun_q <= inrun_d;
        end else if (cmd_i.flush) begin
          inrun_q <= 1'b0;
        end
        pend_v_q <= pend_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q    <= rsp_d;
    pend_s_q <= pend_s_d;
    pend_l_q <= pend_l_d;
    if (cmd_i.load) begin
      cmd_q       <= req_i.cmd;
      start_q     <= req_i.start_req;
      end_q       <= end9[7:0];
      err_q       <= req_err;
      lenz_q      <= (req_i.length == 8'd0);
      last_byte_q <= end_m1[6:3];
      byte_q      <= req_i.start_req[6:3];
      pos_q       <= 3'd0;
    end else if (cmd_i.step) begin
      byte_q <= byte_d;
      if (stat_o.byte_adv) begin
        pos_q <= 3'd0;
      end else begin
        pos_q <= pos_d;
      end
      if (is_scan) begin
        run_s_q <= run_s_d;
        run_l_q <= run_l_d;
      end
    end
  end

  assign rsp_o        = rsp_q;
  assign rsp_strobe_o = strobe_q;

endmodule

/* hw/rtl/page_valid_bitmap_runs.sv */
// Top level of the per-byte page valid bitmap with run extraction.
// Mark and invalidate: the walk handles one bitmap byte a cycle across the bitmap bytes
// that the range touches (1 to 16). Scan: the finder stays on a byte for each run that
// closes inside it, and a flush state follows the walk. An error or an empty range goes
// from decode straight to the final word. Busy stays high until the final word, results
// cannot be stalled, and reset clears the whole bitmap.
module page_valid_bitmap_runs #(
  parameter int PAGE_BYTES = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pvbr_pkg::req_t  req_i,
  output pvbr_pkg::rsp_t  rsp_o,
  output logic            rsp_strobe_o
);

  pvbr_pkg::ctrl_cmd_t ctrl_cmd;
  pvbr_pkg::dp_stat_t  dp_stat;

  pvbr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (ctrl_cmd),
    .busy_o  (busy)
  );

  pvbr_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .rsp_o        (rsp_o),
    .rsp_strobe_o (rsp_strobe_o)
  );

  // The final word of a command is only given once the controller is back in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o && rsp_o.last |-> !busy)
    else $error("final word while busy");

  // Any word that is not final belongs to a command still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o && !rsp_o.last |-> busy)
    else $error("intermediate word while idle");

  // A rejected range produces exactly one word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o && rsp_o.status |-> rsp_o.last)
    else $error("error word not final");

  // No word follows directly after a command is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !rsp_strobe_o)
    else $error("word right after accept");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the page valid bitmap block with run extraction.
module testbench;
  import pvbr_pkg::*;

  localparam int PAGE_SIZE   = 128;
  localparam int MAX_RUNS    = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 120;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    cmd_e       cmd;
    logic [6:0] first;
    logic [7:0] count;
    bit         typed;
    rsp_t       word;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  rsp_t rsp_o;
  logic rsp_strobe_o;

  logic [PAGE_SIZE-1:0] page_bits;
  rsp_t                 pending_words[$];
  stim_row_t            directed_rows[$];
  rsp_t                 want_word;
  int                   n_errors;
  int                   cycle_count;

  page_valid_bitmap_runs #(.PAGE_BYTES(PAGE_SIZE)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_strobe_o(rsp_strobe_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_valid_bitmap_runs verification failed");
      $finish;
    end
  end

  function automatic rsp_t make_word(input logic st, input int rs, input int rl,
                                     input logic em, input logic la);
    rsp_t w;
    w.status     = st;
    w.run_start  = 7'(rs);
    w.run_length = 8'(rl);
    w.page_empty = em;
    w.last       = la;
    return w;
  endfunction

  // Appends one expected word at the tail of the queue.
  function automatic void append_word(input rsp_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Updates the page bitmap for one command and queues the words it should produce.
  function automatic void predict_page_op(input req_t r);
    int   stop;
    int   p;
    int   n;
    int   run_s;
    int   run_l;
    bit   empty;
    bit   have_prev;
    rsp_t prev;
    stop = int'(r.start_req) + int'(r.length);
    if (stop > PAGE_SIZE || r.cmd == CMD_RSVD) begin
      append_word(make_word(1'b1, 0, 0, page_bits == '0, 1'b1));
      return;
    end
    if (r.cmd == CMD_MARK || r.cmd == CMD_INVAL) begin
      for (p = int'(r.start_req); p < stop; p++) page_bits[p] = (r.cmd == CMD_MARK);
      append_word(make_word(1'b0, 0, 0, page_bits == '0, 1'b1));
      return;
    end
    empty     = (page_bits == '0);
    n         = 0;
    run_s     = 0;
    run_l     = 0;
    have_prev = 1'b0;
    prev      = '0;
    // A run is held back one step so that the final one can carry the last flag.
    for (p = int'(r.start_req); p <= stop; p++) begin
      if (p < stop && page_bits[p]) begin
        if (run_l == 0) run_s = p;
        run_l++;
      end else if (run_l != 0) begin
        if (n < MAX_RUNS) begin
          if (have_prev) append_word(prev);
          prev      = make_word(1'b0, run_s, run_l, empty, 1'b0);
          have_prev = 1'b1;
          n++;
        end
        run_l = 0;
      end
    end
    if (have_prev) begin
      prev.last = 1'b1;
      append_word(prev);
    end else begin
      append_word(make_word(1'b0, 0, 0, empty, 1'b1));
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_strobe_o) begin
      if (pending_words.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual %h", $time, rsp_o);
      end else begin
        want_word = pending_words.pop_front();
        if (rsp_o.status !== want_word.status || rsp_o.run_start !== want_word.run_start ||
            rsp_o.run_length !== want_word.run_length ||
            rsp_o.page_empty !== want_word.page_empty || rsp_o.last !== want_word.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: mismatch, expected st=%0d rs=%0d rl=%0d em=%0d la=%0d, %s",
                     $time, want_word.status, want_word.run_start, want_word.run_length,
                     want_word.page_empty, want_word.last,
                     $sformatf("actual st=%0d rs=%0d rl=%0d em=%0d la=%0d", rsp_o.status,
                               rsp_o.run_start, rsp_o.run_length, rsp_o.page_empty,
                               rsp_o.last));
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input req_t w, input bit typed, input rsp_t typed_word);
    bit taken;
    start <= 1'b1;
    req_i <= w;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    predict_page_op(w);
    if (typed) begin
      void'(pending_words.pop_back());
      append_word(typed_word);
    end
    @(negedge clk_i);
  endtask

  task automatic idle_burst(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  task automatic add_row(input cmd_e c, input int f, input int n, input bit typed,
                         input rsp_t w);
    stim_row_t row;
    row.cmd   = c;
    row.first = 7'(f);
    row.count = 8'(n);
    row.typed = typed;
    row.word  = w;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic req_t make_req(input cmd_e c, input int f, input int n);
    req_t r;
    r.cmd       = c;
    r.start_req = 7'(f);
    r.length    = 8'(n);
    return r;
  endfunction

  function automatic req_t random_req();
    int   k;
    int   f;
    int   sel;
    int   n;
    cmd_e c;
    k   = $urandom_range(0, 99);
    f   = $urandom_range(0, PAGE_SIZE - 1);
    sel = $urandom_range(0, 9);
    if (k < 35) c = CMD_MARK;
    else if (k < 60) c = CMD_INVAL;
    else if (k < 92) c = CMD_SCAN;
    else c = CMD_RSVD;
    if (sel <= 5) n = $urandom_range(0, (PAGE_SIZE - f < 16) ? PAGE_SIZE - f : 16);
    else if (sel <= 7) n = $urandom_range(0, PAGE_SIZE - f);
    else if (sel == 8) n = $urandom_range(PAGE_SIZE + 1 - f, 255);
    else n = $urandom_range(0, 255);
    return make_req(c, f, n);
  endfunction

  initial begin
    rsp_t none;
    int   i;
    none        = '0;
    n_errors    = 0;
    cycle_count = 0;
    page_bits   = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_row(CMD_SCAN,    0,   128, 1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_MARK,    0,   0,   1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_INVAL,   0,   0,   1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_SCAN,    64,  0,   1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_RSVD,    0,   0,   1, make_word(1, 0,   0,   1, 1));
    add_row(CMD_MARK,    127, 2,   1, make_word(1, 0,   0,   1, 1));
    add_row(CMD_MARK,    0,   255, 1, make_word(1, 0,   0,   1, 1));
    add_row(CMD_MARK,    0,   128, 1, make_word(0, 0,   0,   0, 1));
    add_row(CMD_SCAN,    0,   128, 1, make_word(0, 0,   128, 0, 1));
    add_row(CMD_SCAN,    127, 1,   1, make_word(0, 127, 1,   0, 1));
    add_row(CMD_INVAL,   0,   128, 1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_MARK,    127, 1,   1, make_word(0, 0,   0,   0, 1));
    add_row(CMD_SCAN,    120, 8,   1, make_word(0, 127, 1,   0, 1));
    add_row(CMD_MARK,    5,   3,   0, none);
    add_row(CMD_MARK,    20,  12,  0, none);
    add_row(CMD_MARK,    8,   4,   0, none);
    add_row(CMD_SCAN,    0,   128, 0, none);
    add_row(CMD_SCAN,    6,   20,  0, none);
    add_row(CMD_INVAL,   25,  2,   0, none);
    add_row(CMD_SCAN,    0,   64,  0, none);
    add_row(CMD_INVAL,   3,   125, 1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_SCAN,    0,   128, 1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_INVAL,   127, 1,   1, make_word(0, 0,   0,   1, 1));
    add_row(CMD_RSVD,    127, 255, 1, make_word(1, 0,   0,   1, 1));
    add_row(CMD_SCAN,    1,   128, 1, make_word(1, 0,   0,   1, 1));

    foreach (directed_rows[i]) begin
      send_word(make_req(directed_rows[i].cmd, directed_rows[i].first, directed_rows[i].count),
                directed_rows[i].typed, directed_rows[i].word);
      idle_burst(30);
    end

    // Hold off until the block has answered everything sent so far.
    start <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);

    // A comb of single valid bytes gives a scan the largest number of runs.
    send_word(make_req(CMD_MARK, 0, PAGE_SIZE), 0, none);
    for (i = 1; i < PAGE_SIZE; i += 2) begin
      send_word(make_req(CMD_INVAL, i, 1), 0, none);
      idle_burst(15);
    end
    send_word(make_req(CMD_SCAN, 0, PAGE_SIZE), 0, none);
    send_word(make_req(CMD_SCAN, 1, PAGE_SIZE - 2), 0, none);

    for (i = 0; i < 125; i++) begin
      send_word(random_req(), 0, none);
      if (i < 95) idle_burst(25);
    end

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("page_valid_bitmap_runs verification clean");
    end else begin
      $display("page_valid_bitmap_runs verification failed");
    end
    $finish;
  end

endmodule
